// ===== rtl/atsm_pkg.sv =====
`timescale 1ns / 1ps

package atsm_pkg;

    localparam int ADAPTER_LEN = 19;
    localparam int LEN_W       = 5;
    localparam int CODE_W      = LEN_W + 1;
    localparam int CHAR_W      = 8;

    localparam logic [LEN_W-1:0] MIN_MATCH_RESET = 5'd8;

    // first character sits in the top byte
    localparam logic [CHAR_W*ADAPTER_LEN-1:0] ADAPTER0_SEQ = "CTGTCTCTTATACACATCT";
    localparam logic [CHAR_W*ADAPTER_LEN-1:0] ADAPTER1_SEQ = "AGATGTGTATAAGAGACAG";

    typedef logic [ADAPTER_LEN-1:0] vec_t;
    typedef logic [LEN_W-1:0]       len_t;

    typedef struct packed {
        logic valid;
        vec_t vec0;
        vec_t vec1;
    } tail_vecs_t;

    // bit j set where character j of the adapter equals c
    function automatic vec_t char_mask(input logic adapter, input logic [CHAR_W-1:0] c);
        logic [CHAR_W*ADAPTER_LEN-1:0] seq;
        vec_t                          m;
        seq = adapter ? ADAPTER1_SEQ : ADAPTER0_SEQ;
        m   = '0;
        for (int j = 0; j < ADAPTER_LEN; j++) begin
            m[j] = (seq[CHAR_W*(ADAPTER_LEN-1-j) +: CHAR_W] == c);
        end
        return m;
    endfunction

    // longest overlap of at least lo, or zero
    function automatic len_t longest_overlap(input vec_t vec, input len_t lo);
        len_t len;
        len = '0;
        for (int j = 0; j < ADAPTER_LEN; j++) begin
            if (vec[j] && ((j + 1) >= int'(lo))) begin
                len = LEN_W'(j + 1);
            end
        end
        return len;
    endfunction

endpackage

// ===== rtl/atsm_match.sv =====
`timescale 1ns / 1ps

module atsm_match (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [atsm_pkg::CHAR_W-1:0] base_char,
    input  logic                        last_base,
    input  logic                        s1_take,
    output atsm_pkg::tail_vecs_t        s1
);
    import atsm_pkg::*;

    vec_t vec0_reg, vec0_next;
    vec_t vec1_reg, vec1_next;
    logic s1_valid_reg, s1_valid_next;
    vec_t s1_vec0_reg, s1_vec1_reg;
    vec_t upd0, upd1;
    logic accept;

    assign in_ready = !s1_valid_reg || s1_take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        upd0 = {vec0_reg[ADAPTER_LEN-2:0], 1'b1} & char_mask(1'b0, base_char);
        upd1 = {vec1_reg[ADAPTER_LEN-2:0], 1'b1} & char_mask(1'b1, base_char);
        vec0_next     = vec0_reg;
        vec1_next     = vec1_reg;
        s1_valid_next = s1_valid_reg && !s1_take;
        if (accept) begin
            if (last_base) begin
                // read ends: hand vectors on and start the next read clean
                vec0_next     = '0;
                vec1_next     = '0;
                s1_valid_next = 1'b1;
            end
            else begin
                vec0_next = upd0;
                vec1_next = upd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vec0_reg     <= '0;
            vec1_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else begin
            vec0_reg     <= vec0_next;
            vec1_reg     <= vec1_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_base) begin
            s1_vec0_reg <= upd0;
            s1_vec1_reg <= upd1;
        end
    end

    assign s1.valid = s1_valid_reg;
    assign s1.vec0  = s1_vec0_reg;
    assign s1.vec1  = s1_vec1_reg;

endmodule

// ===== rtl/atsm_select.sv =====
`timescale 1ns / 1ps

module atsm_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  atsm_pkg::tail_vecs_t        s1,
    input  atsm_pkg::len_t              min_match,
    output logic                        s1_take,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [atsm_pkg::LEN_W-1:0]  overlap_length,
    output logic                        which_adapter,
    output logic [atsm_pkg::CODE_W-1:0] tail_code
);
    import atsm_pkg::*;

    logic out_valid_reg;
    len_t ov_reg, ov_next;
    logic which_reg, which_next;
    len_t lo, len0, len1;

    assign s1_take = s1.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        lo   = (min_match == '0) ? LEN_W'(1) : min_match;
        len0 = longest_overlap(s1.vec0, lo);
        len1 = longest_overlap(s1.vec1, lo);
        // adapter 0 wins whenever it has any qualifying overlap
        if (len0 != '0) begin
            ov_next    = len0;
            which_next = 1'b0;
        end
        else begin
            ov_next    = len1;
            which_next = (len1 != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_take) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take) begin
            ov_reg    <= ov_next;
            which_reg <= which_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign overlap_length = ov_reg;
    assign which_adapter  = which_reg;
    assign tail_code      = {ov_reg, which_reg};

endmodule

// ===== rtl/adapter_tail_suffix_match.sv =====
`timescale 1ns / 1ps
// channel  | handshake            | payload
// -------- | -------------------- | ------------------------------------------
// input    | in_valid / in_ready  | base_char, last_base
// result   | out_valid / out_ready| overlap_length, which_adapter, tail_code
// config   | cfg_we               | cfg_wdata (min_match)
//
// one base per cycle while in_ready is high; the last base of a read passes the
// match stage, then the result register, before its result shows on out_valid.
// rst_n clears the match vectors, both stage valids and sets min_match to 8.
// a held result stalls input only when the stage before it is full too;
// non-last bases produce no result beat.

module adapter_tail_suffix_match (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [atsm_pkg::CHAR_W-1:0] base_char,
    input  logic                        last_base,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [atsm_pkg::LEN_W-1:0]  overlap_length,
    output logic                        which_adapter,
    output logic [atsm_pkg::CODE_W-1:0] tail_code,
    input  logic                        cfg_we,
    input  logic [atsm_pkg::LEN_W-1:0]  cfg_wdata
);
    import atsm_pkg::*;

    len_t       min_match_reg;
    tail_vecs_t s1;
    logic       s1_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_match_reg <= MIN_MATCH_RESET;
        end
        else if (cfg_we) begin
            min_match_reg <= cfg_wdata;
        end
    end

    atsm_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base_char (base_char),
        .last_base (last_base),
        .s1_take   (s1_take),
        .s1        (s1)
    );

    atsm_select u_select (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1             (s1),
        .min_match      (min_match_reg),
        .s1_take        (s1_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .overlap_length (overlap_length),
        .which_adapter  (which_adapter),
        .tail_code      (tail_code)
    );

endmodule

// ===== rtl/atsm_checker.sv =====
`timescale 1ns / 1ps

module atsm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [atsm_pkg::CHAR_W-1:0] base_char,
    input logic                        last_base,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [atsm_pkg::LEN_W-1:0]  overlap_length,
    input logic                        which_adapter,
    input logic [atsm_pkg::CODE_W-1:0] tail_code
);
    import atsm_pkg::*;

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(base_char) && $stable(last_base))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tail_code))
        else $error("result beat changed while stalled");

    a_code_pack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tail_code == {overlap_length, which_adapter})
        else $error("tail_code does not match overlap and adapter");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overlap_length == '0 |-> !which_adapter)
        else $error("adapter flagged without overlap");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(overlap_length) <= ADAPTER_LEN)
        else $error("overlap longer than adapter");

endmodule

bind adapter_tail_suffix_match atsm_checker u_atsm_checker (.*);
